>>> hw/rtl/rthsh_pkg.sv
// Shared types, constants and helpers for the ray/triangle hit shader.
// No dependencies; every other RTL file imports this package.
`default_nettype none
package rthsh_pkg;

    localparam int COORD_BITS = 16;
    localparam int NORM_BITS  = 16;
    localparam int DEN_BITS   = 32;
    localparam int NUM_BITS   = 48;
    localparam int Q_FRAC     = 16;
    localparam int W_BITS     = 42;
    localparam int C_BITS     = 34;
    localparam int DIFF_BITS  = 50;
    localparam int W_SPLIT    = 21;
    localparam int WIDE_BITS  = 76;
    localparam int SAT_BITS   = 63;
    localparam int CFG_BITS   = 48;

    localparam logic signed [WIDE_BITS-1:0] SAT_LIM = {14'b0, 1'b1, 61'b0};

    typedef enum logic [2:0] {
        REG_VERTEX_A     = 3'd0,
        REG_VERTEX_B     = 3'd1,
        REG_VERTEX_C     = 3'd2,
        REG_PLANE_NORMAL = 3'd3,
        REG_PLANE_OFFSET = 3'd4,
        REG_FILL_COLOR   = 3'd5,
        REG_EYE_POSITION = 3'd6,
        REG_PAR_MARGIN   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_BITS-1:0]   vertex_a;
        logic [CFG_BITS-1:0]   vertex_b;
        logic [CFG_BITS-1:0]   vertex_c;
        logic [CFG_BITS-1:0]   plane_normal;
        logic signed [31:0]    plane_offset;
        logic [23:0]           fill_color;
        logic [CFG_BITS-1:0]   eye_position;
        logic [15:0]           parallel_margin;
    } cfg_t;

    typedef struct packed {
        logic [2:0][COORD_BITS-1:0] d;
        logic                       neg;
        logic                       blank;
        logic [DEN_BITS-1:0]        den;
        logic [NUM_BITS-1:0]        num;
        logic [DEN_BITS-1:0]        rem;
        logic [NUM_BITS-1:0]        q;
    } div_word_t;

    typedef struct packed {
        logic                   blank;
        logic [8:0][W_BITS-1:0] w;
    } edge_word_t;

    function automatic logic signed [SAT_BITS-1:0] clamp61(
        input logic signed [WIDE_BITS-1:0] x);
        logic signed [SAT_BITS-1:0] r;
        if (x > SAT_LIM)
            r = SAT_LIM[SAT_BITS-1:0];
        else if (x < -SAT_LIM)
            r = SAT_BITS'(-SAT_LIM);
        else
            r = x[SAT_BITS-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rthsh_front.sv
// Plane step: divider = N . dir, parallel/backface test, division setup.
// Depends on rthsh_pkg.
`default_nettype none
module rthsh_front
    import rthsh_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire cfg_t                   cfg,
    input  wire logic                   in_valid,
    input  wire logic [2:0][COORD_BITS-1:0] in_d,
    output logic                        out_valid,
    output div_word_t                   out_word
);

    logic                        v1_reg;
    logic signed [31:0]          prod_reg [3];
    logic [2:0][COORD_BITS-1:0]  d1_reg;
    logic                        v2_reg;
    div_word_t                   w2_reg;

    logic signed [C_BITS-1:0]    sum;
    logic signed [C_BITS-1:0]    margin;
    logic                        blank;
    logic [31:0]                 mag;
    div_word_t                   w2_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= $signed(cfg.plane_normal[NORM_BITS*i +: NORM_BITS])
                             * $signed(in_d[i]);
            end
            d1_reg <= in_d;
            w2_reg <= w2_next;
        end
    end

    always_comb
    begin
        sum    = C_BITS'(prod_reg[0]) + C_BITS'(prod_reg[1]) + C_BITS'(prod_reg[2]);
        margin = $signed({{(C_BITS-16){1'b0}}, cfg.parallel_margin});
        blank  = (sum <= 0) || (sum < margin);
        mag    = cfg.plane_offset[31] ? (~cfg.plane_offset + 32'd1) : cfg.plane_offset;
        w2_next.d     = d1_reg;
        w2_next.neg   = !cfg.plane_offset[31] && (cfg.plane_offset != 32'sd0);
        w2_next.blank = blank;
        w2_next.den   = blank ? DEN_BITS'(1) : sum[DEN_BITS-1:0];
        w2_next.num   = {mag, {Q_FRAC{1'b0}}};
        w2_next.rem   = '0;
        w2_next.q     = '0;
    end

    assign out_valid = v2_reg;
    assign out_word  = w2_reg;

endmodule
`default_nettype wire

>>> hw/rtl/rthsh_divider.sv
// Restoring divider, one quotient bit per pipeline stage.
// Depends on rthsh_pkg.
`default_nettype none
module rthsh_divider
    import rthsh_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  wire div_word_t  in_word,
    output logic            out_valid,
    output div_word_t       out_word
);

    logic      vld_reg [NUM_BITS];
    div_word_t st_reg  [NUM_BITS];

    for (genvar k = 0; k < NUM_BITS; k++)
    begin : g_stage
        div_word_t          src;
        logic               src_v;
        logic [DEN_BITS:0]  trial;
        logic               ge;
        div_word_t          st_next;

        if (k == 0)
        begin : g_first
            assign src   = in_word;
            assign src_v = in_valid;
        end
        else
        begin : g_rest
            assign src   = st_reg[k-1];
            assign src_v = vld_reg[k-1];
        end

        always_comb
        begin
            trial   = {src.rem, src.num[NUM_BITS-1]};
            ge      = trial >= {1'b0, src.den};
            st_next = src;
            st_next.num = {src.num[NUM_BITS-2:0], 1'b0};
            st_next.q   = {src.q[NUM_BITS-2:0], ge};
            st_next.rem = ge ? DEN_BITS'(trial - {1'b0, src.den}) : trial[DEN_BITS-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= src_v;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[k] <= st_next;
        end
    end

    assign out_valid = vld_reg[NUM_BITS-1];
    assign out_word  = st_reg[NUM_BITS-1];

endmodule
`default_nettype wire

>>> hw/rtl/rthsh_point.sv
// Ray parameter saturation, hit point and per-edge offsets P - T, cut to Q.8.
// Depends on rthsh_pkg.
`default_nettype none
module rthsh_point
    import rthsh_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire cfg_t       cfg,
    input  wire logic       in_valid,
    input  wire div_word_t  in_word,
    output logic            out_valid,
    output edge_word_t      out_word
);

    logic                        v1_reg, v2_reg, v3_reg;
    logic signed [31:0]          t_reg;
    logic [2:0][COORD_BITS-1:0]  d1_reg;
    logic                        b1_reg, b2_reg;
    logic signed [47:0]          prod_reg [3];
    edge_word_t                  w3_reg;

    logic signed [NUM_BITS:0]    ts;
    logic signed [31:0]          t_next;
    edge_word_t                  w3_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_comb
    begin
        ts = $signed({1'b0, in_word.q});
        if (in_word.neg)
            ts = -ts;
        if (ts > $signed(49'sh0_7FFF_FFFF))
            t_next = 32'sh7FFF_FFFF;
        else if (ts < -$signed(49'sh0_8000_0000))
            t_next = 32'sh8000_0000;
        else
            t_next = ts[31:0];
    end

    always_comb
    begin
        logic signed [DIFF_BITS-1:0] base;
        logic signed [DIFF_BITS-1:0] diff;
        logic signed [DIFF_BITS-1:0] adj;
        logic [CFG_BITS-1:0]         vtx;
        w3_next.blank = b2_reg;
        w3_next.w     = '0;
        for (int e = 0; e < 3; e++)
        begin
            vtx = (e == 0) ? cfg.vertex_a : (e == 1) ? cfg.vertex_b : cfg.vertex_c;
            for (int i = 0; i < 3; i++)
            begin
                base = DIFF_BITS'($signed(cfg.eye_position[COORD_BITS*i +: COORD_BITS]))
                     - DIFF_BITS'($signed(vtx[COORD_BITS*i +: COORD_BITS]));
                diff = (base <<< Q_FRAC) + DIFF_BITS'(prod_reg[i]);
                adj  = diff + (diff[DIFF_BITS-1] ? DIFF_BITS'(255) : DIFF_BITS'(0));
                w3_next.w[e*3+i] = adj[DIFF_BITS-1:8];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg  <= t_next;
            d1_reg <= in_word.d;
            b1_reg <= in_word.blank;
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= $signed(d1_reg[i]) * t_reg;
            end
            b2_reg <= b1_reg;
            w3_reg <= w3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_word  = w3_reg;

endmodule
`default_nettype wire

>>> hw/rtl/rthsh_edge.sv
// Same-side edge tests W . (N x E) with saturating sums, hit decision.
// Depends on rthsh_pkg.
`default_nettype none
module rthsh_edge
    import rthsh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire cfg_t        cfg,
    input  wire logic        in_valid,
    input  wire edge_word_t  in_word,
    output logic             out_valid,
    output logic [23:0]      out_color,
    output logic             out_hit
);

    logic signed [16:0]          ed_reg [9];
    logic signed [C_BITS-1:0]    c_reg  [9];

    logic                        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                        b1_reg, b2_reg, b3_reg, b4_reg;
    logic signed [55:0]          pl_reg [9];
    logic signed [54:0]          ph_reg [9];
    logic signed [SAT_BITS-1:0]  pr_reg [9];
    logic signed [SAT_BITS-1:0]  s1_reg [3];
    logic signed [SAT_BITS-1:0]  p2_reg [3];
    logic signed [SAT_BITS-1:0]  s_reg  [3];
    logic [23:0]                 color_reg;
    logic                        hit_reg;

    logic                        all_pos, all_neg, hit_next;

    always_ff @(posedge clk)
    begin
        logic [CFG_BITS-1:0] va, vb;
        logic signed [15:0]  n0, n1, n2;
        n0 = $signed(cfg.plane_normal[15:0]);
        n1 = $signed(cfg.plane_normal[31:16]);
        n2 = $signed(cfg.plane_normal[47:32]);
        for (int e = 0; e < 3; e++)
        begin
            va = (e == 0) ? cfg.vertex_a : (e == 1) ? cfg.vertex_b : cfg.vertex_c;
            vb = (e == 0) ? cfg.vertex_b : (e == 1) ? cfg.vertex_c : cfg.vertex_a;
            for (int i = 0; i < 3; i++)
            begin
                ed_reg[e*3+i] <= 17'($signed(vb[COORD_BITS*i +: COORD_BITS]))
                               - 17'($signed(va[COORD_BITS*i +: COORD_BITS]));
            end
            c_reg[e*3+0] <= C_BITS'(n1 * ed_reg[e*3+2]) - C_BITS'(n2 * ed_reg[e*3+1]);
            c_reg[e*3+1] <= C_BITS'(n2 * ed_reg[e*3+0]) - C_BITS'(n0 * ed_reg[e*3+2]);
            c_reg[e*3+2] <= C_BITS'(n0 * ed_reg[e*3+1]) - C_BITS'(n1 * ed_reg[e*3+0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_comb
    begin
        all_pos  = (s_reg[0] > 0) && (s_reg[1] > 0) && (s_reg[2] > 0);
        all_neg  = (s_reg[0] < 0) && (s_reg[1] < 0) && (s_reg[2] < 0);
        hit_next = !b4_reg && (all_pos || all_neg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                pl_reg[k] <= $signed({1'b0, in_word.w[k][W_SPLIT-1:0]}) * c_reg[k];
                ph_reg[k] <= $signed(in_word.w[k][W_BITS-1:W_SPLIT]) * c_reg[k];
                pr_reg[k] <= clamp61((WIDE_BITS'(ph_reg[k]) <<< W_SPLIT)
                                     + WIDE_BITS'(pl_reg[k]));
            end
            for (int e = 0; e < 3; e++)
            begin
                s1_reg[e] <= clamp61(WIDE_BITS'(pr_reg[e*3+0]) + WIDE_BITS'(pr_reg[e*3+1]));
                p2_reg[e] <= pr_reg[e*3+2];
                s_reg[e]  <= clamp61(WIDE_BITS'(s1_reg[e]) + WIDE_BITS'(p2_reg[e]));
            end
            b1_reg    <= in_word.blank;
            b2_reg    <= b1_reg;
            b3_reg    <= b2_reg;
            b4_reg    <= b3_reg;
            hit_reg   <= hit_next;
            color_reg <= hit_next ? cfg.fill_color : 24'd0;
        end
    end

    assign out_valid = v5_reg;
    assign out_color = color_reg;
    assign out_hit   = hit_reg;

endmodule
`default_nettype wire

>>> hw/rtl/ray_triangle_hit_shader.sv
// Top level of the ray/triangle hit shader: config registers and pipeline.
// Depends on rthsh_pkg, rthsh_front, rthsh_divider, rthsh_point, rthsh_edge.
//
//  channel  | handshake             | word
//  ---------+-----------------------+---------------------------------
//  ray      | ray_valid / ray_stall | ray_x, ray_y, ray_z
//  pixel    | pixel_valid / stall   | pixel_color, hit
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One ray word per cycle while no stall holds it; stages: plane, divider, point,
// edge test. The one-bit-per-stage divider sets the depth.
// The whole pipeline advances together; pixel_stall on a valid result
// freezes every stage and raises ray_stall. cfg_ready is always high.
// Reset clears valid bits and config registers, but parallel_margin resets to 16.
`default_nettype none
module ray_triangle_hit_shader
    import rthsh_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    ray_valid,
    output logic                         ray_stall,
    input  wire logic signed [15:0]      ray_x,
    input  wire logic signed [15:0]      ray_y,
    input  wire logic signed [15:0]      ray_z,
    output logic                         pixel_valid,
    input  wire logic                    pixel_stall,
    output logic [23:0]                  pixel_color,
    output logic                         hit,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [2:0]              cfg_index,
    input  wire logic [CFG_BITS-1:0]     cfg_data
);

    cfg_t        cfg_reg;
    logic        en;
    logic        in_v;
    logic        f_valid, d_valid, p_valid;
    div_word_t   f_word, d_word;
    edge_word_t  p_word;
    logic [2:0][COORD_BITS-1:0] ray_d;

    assign en        = !(pixel_valid && pixel_stall);
    assign ray_stall = !en;
    assign cfg_ready = 1'b1;
    assign in_v      = ray_valid && en;
    assign ray_d     = {ray_z, ray_y, ray_x};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= cfg_t'({{($bits(cfg_t)-16){1'b0}}, 16'd16});
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_VERTEX_A:     cfg_reg.vertex_a        <= cfg_data;
                REG_VERTEX_B:     cfg_reg.vertex_b        <= cfg_data;
                REG_VERTEX_C:     cfg_reg.vertex_c        <= cfg_data;
                REG_PLANE_NORMAL: cfg_reg.plane_normal    <= cfg_data;
                REG_PLANE_OFFSET: cfg_reg.plane_offset    <= $signed(cfg_data[31:0]);
                REG_FILL_COLOR:   cfg_reg.fill_color      <= cfg_data[23:0];
                REG_EYE_POSITION: cfg_reg.eye_position    <= cfg_data;
                REG_PAR_MARGIN:   cfg_reg.parallel_margin <= cfg_data[15:0];
                default:          cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    rthsh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (in_v),
        .in_d      (ray_d),
        .out_valid (f_valid),
        .out_word  (f_word)
    );

    rthsh_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_word   (f_word),
        .out_valid (d_valid),
        .out_word  (d_word)
    );

    rthsh_point u_point (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (d_valid),
        .in_word   (d_word),
        .out_valid (p_valid),
        .out_word  (p_word)
    );

    rthsh_edge u_edge (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (p_valid),
        .in_word   (p_word),
        .out_valid (pixel_valid),
        .out_color (pixel_color),
        .out_hit   (hit)
    );

endmodule
`default_nettype wire

>>> verif/ray_triangle_hit_shader_tb.sv
// Testbench for ray_triangle_hit_shader: drives ray words and register writes,
// and checks each pixel word against a scoreboard that predicts it.
// Depends on rthsh_pkg and the ray_triangle_hit_shader RTL.
`default_nettype none
module ray_triangle_hit_shader_tb;
    import rthsh_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 70;

    class pixel_scoreboard;
        typedef struct {
            bit [23:0] color;
            bit        hit;
        } pixel_t;

        localparam longint SAT = 64'sd1 <<< 61;

        bit [47:0] vertex[3];
        bit [47:0] normal_reg;
        longint    offset;
        bit [23:0] color_reg;
        bit [47:0] eye;
        longint    margin;
        pixel_t    expected_pixels[$];
        int        errors;
        int        rays;
        int        pixels;
        int        hits;

        function new();
            vertex = '{default: 48'd0};
            normal_reg = 0;
            offset = 0;
            color_reg = 0;
            eye = 0;
            margin = 16;
            errors = 0;
            rays = 0;
            pixels = 0;
            hits = 0;
        endfunction

        function void write_reg(reg_idx_t idx, bit [47:0] value);
            case (idx)
                REG_VERTEX_A:     vertex[0] = value;
                REG_VERTEX_B:     vertex[1] = value;
                REG_VERTEX_C:     vertex[2] = value;
                REG_PLANE_NORMAL: normal_reg = value;
                REG_PLANE_OFFSET: offset = longint'($signed(value[31:0]));
                REG_FILL_COLOR:   color_reg = value[23:0];
                REG_EYE_POSITION: eye = value;
                REG_PAR_MARGIN:   margin = longint'(value[15:0]);
                default: ;
            endcase
        endfunction

        function longint clip(longint x);
            if (x > SAT) return SAT;
            if (x < -SAT) return -SAT;
            return x;
        endfunction

        function longint mul_sat(longint a, longint b);
            longint unsigned ua;
            longint unsigned ub;
            bit neg;
            a = clip(a);
            b = clip(b);
            if (a == 0 || b == 0) return 0;
            neg = (a < 0) != (b < 0);
            ua = a < 0 ? -a : a;
            ub = b < 0 ? -b : b;
            if (ua > longint'(SAT) / ub) return neg ? -SAT : SAT;
            return neg ? -longint'(ua * ub) : longint'(ua * ub);
        endfunction

        function longint add_sat(longint a, longint b);
            return clip(clip(a) + clip(b));
        endfunction

        function longint coord(bit [47:0] v, int k);
            return longint'($signed(v[16*k +: 16]));
        endfunction

        function pixel_t shade(bit [15:0] rx, bit [15:0] ry, bit [15:0] rz);
            pixel_t r;
            longint d[3], n[3], p[3], v[3][3];
            longint dv, t, s, ed[3], w[3], c[3];
            int pos, neg;
            r.color = 0;
            r.hit = 0;
            d[0] = longint'($signed(rx));
            d[1] = longint'($signed(ry));
            d[2] = longint'($signed(rz));
            dv = 0;
            pos = 0;
            neg = 0;
            for (int i = 0; i < 3; i++)
            begin
                n[i] = coord(normal_reg, i);
                dv = add_sat(dv, mul_sat(n[i], d[i]));
            end
            if (dv <= 0 || dv < margin) return r;
            t = mul_sat(-offset, 65536) / dv;
            if (t > 64'sd2147483647) t = 64'sd2147483647;
            if (t < -64'sd2147483648) t = -64'sd2147483648;
            for (int i = 0; i < 3; i++)
            begin
                p[i] = add_sat(mul_sat(coord(eye, i), 65536), mul_sat(d[i], t));
                for (int e = 0; e < 3; e++)
                    v[e][i] = coord(vertex[e], i);
            end
            for (int e = 0; e < 3; e++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ed[i] = add_sat(v[(e + 1) % 3][i], -v[e][i]);
                    w[i] = add_sat(p[i], -mul_sat(v[e][i], 65536)) / 256;
                end
                c[0] = add_sat(mul_sat(n[1], ed[2]), -mul_sat(n[2], ed[1]));
                c[1] = add_sat(mul_sat(n[2], ed[0]), -mul_sat(n[0], ed[2]));
                c[2] = add_sat(mul_sat(n[0], ed[1]), -mul_sat(n[1], ed[0]));
                s = 0;
                for (int i = 0; i < 3; i++)
                    s = add_sat(s, mul_sat(w[i], c[i]));
                if (s > 0) pos++;
                else if (s < 0) neg++;
            end
            if (pos == 3 || neg == 3)
            begin
                r.color = color_reg;
                r.hit = 1;
            end
            return r;
        endfunction

        function void note_ray(bit [15:0] rx, bit [15:0] ry, bit [15:0] rz);
            expected_pixels.push_back(shade(rx, ry, rz));
            rays++;
        endfunction

        function void check_pixel(bit [23:0] color, bit hit_bit);
            pixel_t e;
            pixels++;
            if (hit_bit) hits++;
            if (expected_pixels.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected pixel word: color %h hit %b", color, hit_bit);
                return;
            end
            e = expected_pixels.pop_front();
            if (e.color !== color || e.hit !== hit_bit)
            begin
                errors++;
                if (errors <= 10)
                    $display("pixel %0d mismatch: expected color %h hit %b, got color %h hit %b",
                             pixels, e.color, e.hit, color, hit_bit);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               ray_valid;
    logic               ray_stall;
    logic signed [15:0] ray_x;
    logic signed [15:0] ray_y;
    logic signed [15:0] ray_z;
    logic               pixel_valid;
    logic               pixel_stall;
    logic [23:0]        pixel_color;
    logic               hit;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    pixel_scoreboard sb;
    bit quiet;
    int idle_cycles;

    ray_triangle_hit_shader u_top (
        .clk(clk), .rst_n(rst_n),
        .ray_valid(ray_valid), .ray_stall(ray_stall),
        .ray_x(ray_x), .ray_y(ray_y), .ray_z(ray_z),
        .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
        .pixel_color(pixel_color), .hit(hit),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles++;
            if (cfg_valid && cfg_ready)
                sb.write_reg(reg_idx_t'(cfg_index), cfg_data);
            if (ray_valid && !ray_stall)
            begin
                sb.note_ray(ray_x, ray_y, ray_z);
                idle_cycles = 0;
            end
            if (pixel_valid && !pixel_stall)
            begin
                sb.check_pixel(pixel_color, hit);
                idle_cycles = 0;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        pixel_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 9) == 0)
            begin
                pixel_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                pixel_stall <= 1'b0;
            end
        end
    end

    function automatic bit [47:0] pack3(int x, int y, int z);
        return {z[15:0], y[15:0], x[15:0]};
    endfunction

    // leaves cfg_valid high; the caller drops it after the batch
    task automatic write_reg(reg_idx_t idx, bit [47:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic write_scene(bit [47:0] a, bit [47:0] b, bit [47:0] c, bit [47:0] n,
                               bit [47:0] off, bit [47:0] color, bit [47:0] eye_pos,
                               bit [47:0] marg);
        write_reg(REG_VERTEX_A, a);
        write_reg(REG_VERTEX_B, b);
        write_reg(REG_VERTEX_C, c);
        write_reg(REG_PLANE_NORMAL, n);
        write_reg(REG_PLANE_OFFSET, off);
        write_reg(REG_FILL_COLOR, color);
        write_reg(REG_EYE_POSITION, eye_pos);
        write_reg(REG_PAR_MARGIN, marg);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_ray(int x, int y, int z);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            ray_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        ray_valid <= 1'b1;
        ray_x <= x[15:0];
        ray_y <= y[15:0];
        ray_z <= z[15:0];
        do @(posedge clk); while (ray_stall);
    endtask

    task automatic end_burst();
        ray_valid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // aimed: rays mostly toward the triangle window; flip negates z for a back-facing plane
    task automatic send_rays(int count, bit aimed, bit flip);
        int dz;
        for (int i = 0; i < count; i++)
        begin
            if (aimed && $urandom_range(0, 9) != 0)
            begin
                dz = $urandom_range(1, 300);
                send_ray($urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300,
                         flip ? -dz : dz);
            end
            else
                send_ray($urandom, $urandom, $urandom);
        end
        end_burst();
    endtask

    initial
    begin
        sb = new();
        quiet = 1'b0;
        idle_cycles = 0;
        rst_n = 1'b0;
        ray_valid = 1'b0;
        ray_x = 0;
        ray_y = 0;
        ray_z = 0;
        cfg_valid = 1'b0;
        cfg_index = REG_VERTEX_A;
        cfg_data = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: zero normal, every pixel black
        send_ray(0, 0, 1);
        send_ray(32767, 32767, 32767);
        send_ray(-32768, -32768, -32768);
        send_rays(10, 1'b0, 1'b0);

        // triangle on plane z = 100, eye at origin
        write_scene(pack3(-50, -50, 100), pack3(60, -40, 100), pack3(0, 70, 100),
                    pack3(0, 0, 16384), 48'(-32'sd1638400), 48'hA5C35A,
                    pack3(0, 0, 0), 48'd16);
        send_ray(0, 0, 1);
        send_ray(0, 0, 100);
        send_ray(-50, -50, 100);
        send_ray(60, -40, 100);
        send_ray(5, 10, 0);
        send_ray(0, 0, -1);
        send_ray(1000, 0, 1);
        send_ray(32767, 32767, 32767);
        send_ray(-32768, -32768, -32768);
        send_ray(0, 0, 32767);
        send_ray(0, 1, -32768);
        end_burst();
        send_rays(280, 1'b1, 1'b0);

        // zero margin: zero divider still parallel
        write_scene(pack3(-50, -50, 100), pack3(60, -40, 100), pack3(0, 70, 100),
                    pack3(0, 0, 16384), 48'(-32'sd1638400), 48'hFFFFFF,
                    pack3(0, 0, 0), 48'd0);
        send_ray(7, 7, 0);
        send_rays(40, 1'b1, 1'b0);

        // back-facing normal, eye offset, largest margin, then a margin of 1
        write_scene(pack3(-50, -50, -100), pack3(0, 70, -100), pack3(60, -40, -100),
                    pack3(0, 0, -16384), 48'(-32'sd1638400), 48'h123456,
                    pack3(3, -4, 0), 48'hFFFF);
        send_rays(30, 1'b1, 1'b1);
        write_scene(pack3(-50, -50, -100), pack3(0, 70, -100), pack3(60, -40, -100),
                    pack3(0, 0, -16384), 48'(-32'sd1638400), 48'h00FF00,
                    pack3(3, -4, 0), 48'd1);
        send_rays(150, 1'b1, 1'b1);

        // register extremes
        write_scene('1, '1, '1, '1, 48'h7FFFFFFF, '1, '1, 48'd0);
        send_rays(30, 1'b0, 1'b0);
        write_scene(pack3(-32768, -32768, -32768), pack3(32767, -32768, 32767),
                    pack3(0, 32767, -32768), pack3(32767, -32768, 32767),
                    48'h80000000, 48'd0, pack3(32767, 32767, -32768), 48'hFFFF);
        send_rays(30, 1'b0, 1'b0);

        // random registers
        for (int k = 0; k < 5; k++)
        begin
            write_scene(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                        48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                        48'({$urandom, $urandom}), 48'($urandom),
                        48'({$urandom, $urandom}), 48'($urandom_range(0, 64)));
            send_rays(25, 1'b0, 1'b0);
        end

        // closing stretch without idling on either side
        write_scene(pack3(-50, -50, 100), pack3(60, -40, 100), pack3(0, 70, 100),
                    pack3(0, 0, 16384), 48'(-32'sd1638400), 48'h3C3C3C,
                    pack3(0, 0, 0), 48'd16);
        quiet = 1'b1;
        send_rays(80, 1'b1, 1'b0);

        $display("covered %0d rays over several triangle and register setups, %0d hits",
                 sb.rays, sb.hits);
        if (sb.errors == 0 && sb.expected_pixels.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

>>> ray_triangle_hit_shader.f
hw/rtl/rthsh_pkg.sv
hw/rtl/rthsh_front.sv
hw/rtl/rthsh_divider.sv
hw/rtl/rthsh_point.sv
hw/rtl/rthsh_edge.sv
hw/rtl/ray_triangle_hit_shader.sv
verif/ray_triangle_hit_shader_tb.sv
